>>> rtl/core/kmd_pkg.sv
// Shared types and constants for the key matrix debouncer.
package kmd_pkg;

    // Matrix geometry defaults
    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 32;

    // Field widths
    localparam int ROW_W    = 3;
    localparam int COL_W    = 5;
    localparam int TIME_W   = 32;
    localparam int KIDX_W   = 8;
    localparam int IDX_W    = 9;   // row * columns + col before the range check
    localparam int DBNC_W   = 16;
    localparam int NCOL_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // Register reset values
    localparam logic [DBNC_W-1:0] DEBOUNCE_RST = 16'd30;
    localparam logic [NCOL_W-1:0] COLUMNS_RST  = 6'd20;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_MS = 1'b0,
        REG_ACTIVE_COLS = 1'b1
    } t_cfg_reg;

    // Per-key record kept in the store
    typedef struct packed {
        logic              stable;
        logic              candidate;
        logic              pending;
        logic [TIME_W-1:0] first_seen;
    } t_key_rec;

    localparam int REC_W = $bits(t_key_rec);

    // One debounced event
    typedef struct packed {
        logic              pressed;
        logic [KIDX_W-1:0] key_index;
    } t_key_evt;

endpackage

>>> rtl/core/kmd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/key_matrix_debouncer.sv
// Top level of the per-key debouncer for an active-low key matrix.
//
//  channel   | dir | transaction carries
//  ----------+-----+----------------------------------------------
//  s_axis    | in  | one matrix sample: row, col, pin_level, now_ms
//  m_axis    | out | one debounced event: key_index, pressed
//  cfg       | in  | register write: debounce_ms, active_columns
//
// One sample is taken every cycle unless the input stalls. A sample reads
// its key record in the cycle it is accepted and is resolved and written
// back in the next, when any event is pushed into the result queue.
// Back-to-back samples of the same key are served by forwarding the record
// just written. A four-entry result queue lets samples keep flowing while
// the output stalls; input stalls when it has no room for every sample in
// flight. Reset clears the record store at once via one valid bit per key.
module key_matrix_debouncer #(
    parameter int MAX_ROWS = kmd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = kmd_pkg::MAX_COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // row[2:0], col[7:3], pin_level[8], now_ms[40:9], zero [47:41]
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [kmd_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // key_index[7:0], pressed[8], zero [15:9]
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [kmd_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kmd_pkg::CFG_DAT_W-1:0]   i_cfg_wdata
);

    import kmd_pkg::*;

    localparam int KEY_COUNT = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    // Configuration registers
    logic [DBNC_W-1:0] r_debounce_ms;
    logic [NCOL_W-1:0] r_active_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RST;
            r_active_cols <= COLUMNS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_wdata[DBNC_W-1:0];
                REG_ACTIVE_COLS: r_active_cols <= i_cfg_wdata[NCOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Input unpack
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic              in_pin;
    logic [TIME_W-1:0] in_now;

    assign in_row = i_s_axis_tdata[ROW_W-1:0];
    assign in_col = i_s_axis_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_pin = i_s_axis_tdata[ROW_W+COL_W];
    assign in_now = i_s_axis_tdata[ROW_W+COL_W+TIME_W:ROW_W+COL_W+1];

    // Key index and range checks
    logic              s_accept;
    logic [IDX_W-1:0]  in_idx;
    logic              in_ok;
    logic [ADDR_W-1:0] in_addr;

    assign s_accept = i_s_axis_tvalid & o_s_axis_tready;
    assign in_idx   = IDX_W'(in_row) * IDX_W'(r_active_cols) + IDX_W'(in_col);
    assign in_ok    = ({1'b0, in_col} < r_active_cols)
                    && ({1'b0, in_row} < (ROW_W+1)'(MAX_ROWS))
                    && (in_idx < IDX_W'(KEY_COUNT));
    assign in_addr  = in_idx[ADDR_W-1:0];

    // Resolve stage registers
    logic              r_s1_vld;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [KIDX_W-1:0] r_s1_kidx;
    logic              r_s1_pin;
    logic [TIME_W-1:0] r_s1_now;
    logic              r_s1_rd_vld;

    // Per-key valid bits and forwarding copy of the last write
    logic [KEY_COUNT-1:0] r_key_vld;
    logic                 r_fwd_vld;
    logic [ADDR_W-1:0]    r_fwd_addr;
    t_key_rec             r_fwd_rec;

    logic [REC_W-1:0] ram_rdata;
    t_key_rec         n_rec;

    kmd_ram #(
        .WIDTH (REC_W),
        .DEPTH (KEY_COUNT)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_addr),
        .i_wdata (n_rec),
        .i_re    (s_accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= s_accept & in_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_addr   <= in_addr;
            r_s1_kidx   <= in_idx[KIDX_W-1:0];
            r_s1_pin    <= in_pin;
            r_s1_now    <= in_now;
            r_s1_rd_vld <= r_key_vld[in_addr];
        end
    end

    // Current record: forwarded, stored, or cleared
    t_key_rec cur_rec;
    logic     fwd_hit;

    assign fwd_hit = r_fwd_vld && (r_fwd_addr == r_s1_addr);

    always_comb begin
        if (fwd_hit) begin
            cur_rec = r_fwd_rec;
        end else if (r_s1_rd_vld) begin
            cur_rec = t_key_rec'(ram_rdata);
        end else begin
            cur_rec = '0;
        end
    end

    // Debounce update
    logic              sampled;
    logic              arm;
    logic              cand;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] elapsed;
    logic              expire;
    logic              emit;

    assign sampled = ~r_s1_pin;
    assign arm     = (sampled != cur_rec.stable) && !cur_rec.pending;
    assign cand    = arm ? sampled : cur_rec.candidate;
    assign first   = arm ? r_s1_now : cur_rec.first_seen;
    assign elapsed = r_s1_now - first;
    assign expire  = (elapsed > TIME_W'(r_debounce_ms)) && (cur_rec.pending || arm);
    assign emit    = expire && (sampled == cand);

    always_comb begin
        n_rec.candidate  = cand;
        n_rec.first_seen = first;
        n_rec.pending    = (cur_rec.pending || arm) && !expire;
        n_rec.stable     = emit ? sampled : cur_rec.stable;
    end

    // Valid bits and forwarding copy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= '0;
            r_fwd_vld <= 1'b0;
        end else if (r_s1_vld) begin
            r_key_vld[r_s1_addr] <= 1'b1;
            r_fwd_vld            <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_rec  <= n_rec;
        end
    end

    // Result queue
    t_key_evt            r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wptr;
    logic [OQ_PTR_W-1:0] r_oq_rptr;
    logic [OQ_CNT_W-1:0] r_oq_cnt;
    logic                oq_push;
    logic                oq_pop;
    t_key_evt            oq_head;

    assign oq_push = r_s1_vld & emit;
    assign oq_pop  = o_m_axis_tvalid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wptr <= '0;
            r_oq_rptr <= '0;
            r_oq_cnt  <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wptr <= r_oq_wptr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rptr <= r_oq_rptr + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wptr] <= '{pressed: sampled, key_index: r_s1_kidx};
        end
    end

    assign oq_head = r_oq[r_oq_rptr];

    // Take a sample only while the queue has room for everything in flight
    assign o_s_axis_tready = (r_oq_cnt + OQ_CNT_W'(r_s1_vld)) < OQ_CNT_W'(OQ_DEPTH);
    assign o_m_axis_tvalid = (r_oq_cnt != '0);
    assign o_m_axis_tdata  = M_TDATA_W'(oq_head);

endmodule
